// ===== rtl/mouse_multi_click_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mouse multi-click detector
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOUSE_MULTI_CLICK_DETECTOR_TOP_ASSERT_SVH
`define MOUSE_MULTI_CLICK_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcd assertion failed");

// Next-cycle implication.
`define MCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcd assertion failed");

`else

`define MCD_ASSERT_IMP(lbl, ante, cons)
`define MCD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/mcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcd_pkg
// Fixed widths, input modes, register indexes, reset values, limits and queue sizes.
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam int MODE_W  = 2;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;
    localparam int TICK_W  = 8;
    localparam int CLICK_W = 8;
    localparam int DELAY_W = 16;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_BUTTON  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POINTER = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_DCLICK_TICKS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_EXTEND_TICKS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MOVE_THRESH  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DCLICK_TICKS_RST = 8'd5;
    localparam logic [CFG_W-1:0] EXTEND_TICKS_RST = 8'd3;
    localparam logic [CFG_W-1:0] MOVE_THRESH_RST  = 8'd2;

    localparam logic [CLICK_W-1:0] CLICK_ONE = 8'd1;
    localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;
    localparam logic [DELAY_W-1:0] DELAY_MAX = 16'hFFFF;

    // Result queue
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = 2;
    localparam int EVQ_CNT_W = 3;

endpackage

// ===== rtl/mouse_multi_click_detector_top.sv =====
// ----------------------------------------------------------------------------
// Mouse multi-click detector, top level
// Turns button changes, timer ticks and pointer moves into click events.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): one beat carries mode, buttons,
//     multi_click_wanted, tick_amount, pointer_x and pointer_y.
//   out channel (out_valid/out_ready): zero, one or two beats per input beat,
//     each with event_buttons, event_clicks and last_of_run (final event).
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): window length,
//     extension per click, move threshold. Always ready; write only while
//     no beat is in flight.
// Timing: a beat is held in the input register until two of the four queue
//   slots are free, then decoded; its events enter the queue and show on the out
//   channel from there. One input per cycle while two queue slots are free; the
//   out channel moves one event per cycle while out_ready is high.
// Reset: all state and the queue clear, registers take their defaults.
// Stall: with out_ready low the queue holds; once fewer than two slots are
//   free the input register holds and in_ready drops.
// ----------------------------------------------------------------------------
module mouse_multi_click_detector_top
    import mcd_pkg::*;
#(
    parameter int BUTTON_BITS = 8,
    parameter int COORD_BITS  = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [BUTTON_BITS-1:0] buttons,
    input  logic                   multi_click_wanted,
    input  logic [TICK_W-1:0]      tick_amount,
    input  logic [COORD_BITS-1:0]  pointer_x,
    input  logic [COORD_BITS-1:0]  pointer_y,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BUTTON_BITS-1:0] event_buttons,
    output logic [CLICK_W-1:0]     event_clicks,
    output logic                   last_of_run,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CIDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    typedef struct packed {
        logic [BUTTON_BITS-1:0] buttons;
        logic [CLICK_W-1:0]     clicks;
        logic                   last;
    } evt_t;

    localparam logic [EVQ_CNT_W-1:0] EVQ_ROOM2 = EVQ_CNT_W'(EVQ_DEPTH - 2);

    // Configuration registers
    logic [CFG_W-1:0] dclick_ticks_reg;
    logic [CFG_W-1:0] extend_ticks_reg;
    logic [CFG_W-1:0] move_thresh_reg;

    // Input register
    logic                   item_vld_reg;
    logic [MODE_W-1:0]      item_mode_reg;
    logic [BUTTON_BITS-1:0] item_btn_reg;
    logic                   item_multi_reg;
    logic [TICK_W-1:0]      item_tick_reg;
    logic [COORD_BITS-1:0]  item_x_reg;
    logic [COORD_BITS-1:0]  item_y_reg;

    // Detector state
    logic [BUTTON_BITS-1:0] true_btn_reg,  true_btn_next;
    logic [BUTTON_BITS-1:0] desired_reg,   desired_next;
    logic [CLICK_W-1:0]     click_reg,     click_next;
    logic [DELAY_W-1:0]     delay_reg,     delay_next;
    logic [COORD_BITS-1:0]  last_x_reg,    last_x_next;
    logic [COORD_BITS-1:0]  last_y_reg,    last_y_next;

    // Event queue
    evt_t                   evq_reg [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   wr_ptr_reg;
    logic [EVQ_PTR_W-1:0]   rd_ptr_reg;
    logic [EVQ_CNT_W-1:0]   cnt_reg;

    logic                   in_fire;
    logic                   proc_fire;
    logic                   pop;
    logic [1:0]             res_n;
    evt_t                   res0;
    evt_t                   res1;

    logic [DELAY_W:0]       delay_ext;
    logic [DELAY_W-1:0]     tick_amt;
    logic [COORD_BITS-1:0]  dx;
    logic [COORD_BITS-1:0]  dy;
    logic [COORD_BITS-1:0]  thresh;
    logic                   moved;

    assign cfg_ready = 1'b1;

    // Decode the held beat once two queue slots are free.
    assign proc_fire = item_vld_reg && (cnt_reg <= EVQ_ROOM2);
    assign in_ready  = !item_vld_reg || proc_fire;
    assign in_fire   = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dclick_ticks_reg <= DCLICK_TICKS_RST;
            extend_ticks_reg <= EXTEND_TICKS_RST;
            move_thresh_reg  <= MOVE_THRESH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DCLICK_TICKS: dclick_ticks_reg <= cfg_data;
                CFG_EXTEND_TICKS: extend_ticks_reg <= cfg_data;
                CFG_MOVE_THRESH:  move_thresh_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (in_fire)
            item_vld_reg <= 1'b1;
        else if (proc_fire)
            item_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_mode_reg  <= mode;
            item_btn_reg   <= buttons;
            item_multi_reg <= multi_click_wanted;
            item_tick_reg  <= tick_amount;
            item_x_reg     <= pointer_x;
            item_y_reg     <= pointer_y;
        end
    end

    // Window arithmetic
    assign delay_ext = {1'b0, delay_reg} + {{(DELAY_W + 1 - CFG_W){1'b0}}, extend_ticks_reg};
    assign tick_amt  = {{(DELAY_W - TICK_W){1'b0}}, item_tick_reg};
    assign dx        = (last_x_reg > item_x_reg) ? (last_x_reg - item_x_reg)
                                                 : (item_x_reg - last_x_reg);
    assign dy        = (last_y_reg > item_y_reg) ? (last_y_reg - item_y_reg)
                                                 : (item_y_reg - last_y_reg);
    assign thresh    = COORD_BITS'(move_thresh_reg);
    assign moved     = (dx > thresh) || (dy > thresh);

    always_comb
    begin
        true_btn_next = true_btn_reg;
        desired_next  = desired_reg;
        click_next    = click_reg;
        delay_next    = delay_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        res_n         = 2'd0;
        res0          = '{buttons: desired_reg, clicks: click_reg, last: 1'b0};
        res1          = '{buttons: true_btn_reg, clicks: CLICK_ONE, last: 1'b1};

        case (item_mode_reg)
            MODE_BUTTON:
            begin
                if (item_btn_reg != true_btn_reg)
                begin
                    if (delay_reg != '0)
                    begin
                        // Matching change inside the window: count it, stretch the window.
                        if (item_btn_reg == desired_reg)
                        begin
                            if (click_reg != CLICK_MAX)
                                click_next = click_reg + CLICK_ONE;
                            delay_next = delay_ext[DELAY_W] ? DELAY_MAX
                                                            : delay_ext[DELAY_W-1:0];
                        end
                    end
                    else if (item_multi_reg && (item_btn_reg != '0) &&
                             (dclick_ticks_reg != '0))
                    begin
                        click_next   = CLICK_ONE;
                        desired_next = item_btn_reg;
                        delay_next   = {{(DELAY_W - CFG_W){1'b0}}, dclick_ticks_reg};
                    end
                    else
                    begin
                        res_n = 2'd1;
                        res0  = '{buttons: item_btn_reg, clicks: CLICK_ONE, last: 1'b1};
                    end
                    true_btn_next = item_btn_reg;
                end
            end
            MODE_TICK:
            begin
                if ((delay_reg != '0) && (item_tick_reg != '0))
                begin
                    if (tick_amt >= delay_reg)
                    begin
                        delay_next = '0;
                        if (desired_reg != true_btn_reg)
                            res_n = 2'd2;
                        else
                            res_n = 2'd1;
                        res0.last = (desired_reg == true_btn_reg);
                    end
                    else
                    begin
                        delay_next = delay_reg - tick_amt;
                    end
                end
            end
            MODE_POINTER:
            begin
                if ((delay_reg != '0) && moved)
                begin
                    delay_next = '0;
                    if (desired_reg != true_btn_reg)
                        res_n = 2'd2;
                    else
                        res_n = 2'd1;
                    res0.last = (desired_reg == true_btn_reg);
                end
                last_x_next = item_x_reg;
                last_y_next = item_y_reg;
            end
            default:
            begin
                // Unused mode: drop the beat.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            true_btn_reg <= '0;
            desired_reg  <= '0;
            click_reg    <= '0;
            delay_reg    <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
        end
        else if (proc_fire)
        begin
            true_btn_reg <= true_btn_next;
            desired_reg  <= desired_next;
            click_reg    <= click_next;
            delay_reg    <= delay_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
        end
    end

    // Event queue: push up to two events, pop one.
    always_ff @(posedge clk)
    begin
        if (proc_fire && (res_n != 2'd0))
            evq_reg[wr_ptr_reg] <= res0;
        if (proc_fire && (res_n == 2'd2))
            evq_reg[wr_ptr_reg + EVQ_PTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (proc_fire)
                wr_ptr_reg <= wr_ptr_reg + EVQ_PTR_W'(res_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + EVQ_PTR_W'(1);
            cnt_reg <= cnt_reg + (proc_fire ? EVQ_CNT_W'(res_n) : '0)
                               - EVQ_CNT_W'(pop);
        end
    end

    assign out_valid     = (cnt_reg != '0);
    assign event_buttons = evq_reg[rd_ptr_reg].buttons;
    assign event_clicks  = evq_reg[rd_ptr_reg].clicks;
    assign last_of_run   = evq_reg[rd_ptr_reg].last;

    `include "mouse_multi_click_detector_top_assert.svh"

    // An open window always carries at least one click.
    `MCD_ASSERT_IMP(a_window_has_click, delay_reg != '0, click_reg != '0)
    // Every decode that emits events leaves the window closed.
    `MCD_ASSERT_NXT(a_emit_closes_window, proc_fire && (res_n != 2'd0), delay_reg == '0)
    // The queue never overflows.
    `MCD_ASSERT_IMP(a_queue_bound, 1'b1, cnt_reg <= EVQ_CNT_W'(EVQ_DEPTH))

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse multi-click detector testbench
// Drives button, tick and pointer beats through the input channel and checks
// every click event against a cycle-free tracker of the detector's state.
// A short plan of directed beats comes first, then phases of random beats
// under different window settings and idle patterns, then a run that drives
// the click count and the window length into saturation.
// ----------------------------------------------------------------------------
module tb;
    import mcd_pkg::*;

    localparam int BTN_W         = 8;
    localparam int CRD_W         = 12;
    localparam int GAP_MAX       = 19;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 5;
    localparam int PHASE_BEATS   = 200;
    localparam int FAV_SPAN      = 40;
    localparam int SAT_TOGGLES   = 520;

    // The fourth input mode is unused by the detector.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BTN_W-1:0]  buttons;
        logic              multi;
        logic [TICK_W-1:0] tick;
        logic [CRD_W-1:0]  x;
        logic [CRD_W-1:0]  y;
    } mouse_beat_t;

    typedef struct packed {
        logic [BTN_W-1:0]   buttons;
        logic [CLICK_W-1:0] clicks;
        logic               last;
    } click_event_t;

    localparam click_event_t NO_EVENT = '0;

    // Plan rows: a beat with events typed in, a beat left to the tracker,
    // or a full rewrite of the three registers.
    typedef enum {ROW_TYPED, ROW_TRACKED, ROW_REGS} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        mouse_beat_t   stim;
        int            n_ev;
        click_event_t  ev0;
        click_event_t  ev1;
        logic [CFG_W-1:0] dct;
        logic [CFG_W-1:0] ext;
        logic [CFG_W-1:0] thr;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------------
    logic               clk                = 1'b0;
    logic               rst_n              = 1'b0;

    logic               in_valid           = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  mode               = MODE_BUTTON;
    logic [BTN_W-1:0]   buttons            = '0;
    logic               multi_click_wanted = 1'b0;
    logic [TICK_W-1:0]  tick_amount        = '0;
    logic [CRD_W-1:0]   pointer_x          = '0;
    logic [CRD_W-1:0]   pointer_y          = '0;

    logic               out_valid;
    logic               out_ready          = 1'b0;
    logic [BTN_W-1:0]   event_buttons;
    logic [CLICK_W-1:0] event_clicks;
    logic               last_of_run;

    logic               cfg_valid          = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index          = CFG_DCLICK_TICKS;
    logic [CFG_W-1:0]   cfg_data           = '0;

    always #5 clk = ~clk;

    mouse_multi_click_detector_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .buttons            (buttons),
        .multi_click_wanted (multi_click_wanted),
        .tick_amount        (tick_amount),
        .pointer_x          (pointer_x),
        .pointer_y          (pointer_y),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .event_buttons      (event_buttons),
        .event_clicks       (event_clicks),
        .last_of_run        (last_of_run),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Click tracker: registers and state as the detector should hold them
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]   win_ticks  = DCLICK_TICKS_RST;
    logic [CFG_W-1:0]   ext_ticks  = EXTEND_TICKS_RST;
    logic [CFG_W-1:0]   move_thr   = MOVE_THRESH_RST;
    logic [BTN_W-1:0]   true_btn   = '0;
    logic [BTN_W-1:0]   want_btn   = '0;
    logic [CLICK_W-1:0] click_cnt  = '0;
    logic [DELAY_W-1:0] delay_left = '0;
    logic [CRD_W-1:0]   last_x     = '0;
    logic [CRD_W-1:0]   last_y     = '0;

    click_event_t step_events [$];   // events of the beat just accepted
    click_event_t events_due  [$];   // events still to come out, oldest first
    plan_row_t    plan        [$];

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int faults      = 0;
    int idle_cycles = 0;

    function automatic logic [CRD_W-1:0] span(logic [CRD_W-1:0] a, logic [CRD_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Close the window: report the desired state with its clicks, then the
    // true state once if the buttons have moved on since.
    function automatic void close_window();
        delay_left = '0;
        step_events.push_back('{want_btn, click_cnt, 1'b0});
        if (want_btn != true_btn)
            step_events.push_back('{true_btn, CLICK_ONE, 1'b0});
    endfunction

    // Advance the tracker by one accepted beat; its events land in step_events.
    function automatic void derive_events(mouse_beat_t s);
        logic [DELAY_W:0] grown;
        step_events.delete();
        case (s.mode)
            MODE_BUTTON:
                if (s.buttons != true_btn)
                begin
                    if (delay_left != '0)
                    begin
                        // Only a return to the desired state counts as a click.
                        if (s.buttons == want_btn)
                        begin
                            if (click_cnt != CLICK_MAX)
                                click_cnt = click_cnt + CLICK_ONE;
                            grown = {1'b0, delay_left} + (DELAY_W+1)'(ext_ticks);
                            delay_left = grown[DELAY_W] ? DELAY_MAX : grown[DELAY_W-1:0];
                        end
                    end
                    else if (s.multi && s.buttons != '0 && win_ticks != '0)
                    begin
                        click_cnt  = CLICK_ONE;
                        want_btn   = s.buttons;
                        delay_left = DELAY_W'(win_ticks);
                    end
                    else
                        step_events.push_back('{s.buttons, CLICK_ONE, 1'b0});
                    true_btn = s.buttons;
                end
            MODE_TICK:
                if (delay_left != '0 && s.tick != '0)
                begin
                    if (DELAY_W'(s.tick) >= delay_left)
                        close_window();
                    else
                        delay_left = delay_left - DELAY_W'(s.tick);
                end
            MODE_POINTER:
            begin
                if (delay_left != '0 &&
                    (span(last_x, s.x) > CRD_W'(move_thr) ||
                     span(last_y, s.y) > CRD_W'(move_thr)))
                    close_window();
                last_x = s.x;
                last_y = s.y;
            end
            default:
                ;
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size()-1].last = 1'b1;
    endfunction

    function automatic void queue_step();
        foreach (step_events[k])
            events_due.push_back(step_events[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, GAP_MAX)) : 0;
    endfunction

    function automatic mouse_beat_t beat(logic [MODE_W-1:0] m, logic [BTN_W-1:0] b,
                                         logic mc, logic [TICK_W-1:0] t,
                                         logic [CRD_W-1:0] px, logic [CRD_W-1:0] py);
        return '{m, b, mc, t, px, py};
    endfunction

    function automatic void add_row(row_kind_t kind, mouse_beat_t stim, int n_ev,
                                    click_event_t e0, click_event_t e1);
        plan.push_back('{kind, stim, n_ev, e0, e1, '0, '0, '0});
    endfunction

    function automatic void add_regs(logic [CFG_W-1:0] d, logic [CFG_W-1:0] e,
                                     logic [CFG_W-1:0] t);
        plan.push_back('{ROW_REGS, '0, 0, NO_EVENT, NO_EVENT, d, e, t});
    endfunction

    // Random beat, weighted toward the sequences that open, extend and close
    // windows: presses of a favorite state, releases, small ticks and small
    // pointer moves around the threshold. Unused fields carry noise.
    function automatic mouse_beat_t pick_beat(logic [BTN_W-1:0] fav);
        mouse_beat_t s;
        int          roll;
        int          jit;
        s.mode    = MODE_SPARE;
        s.buttons = BTN_W'($urandom);
        s.multi   = 1'($urandom);
        s.tick    = TICK_W'($urandom);
        s.x       = CRD_W'($urandom);
        s.y       = CRD_W'($urandom);
        roll      = $urandom_range(0, 99);
        jit       = int'(move_thr) + 1;
        if (roll < 45)
        begin
            s.mode  = MODE_BUTTON;
            s.multi = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: s.buttons = fav;
                4, 5, 6, 7: s.buttons = '0;
                8:          s.buttons = fav ^ (BTN_W'(1) << $urandom_range(0, BTN_W-1));
                default:    ;
            endcase
        end
        else if (roll < 75)
        begin
            s.mode = MODE_TICK;
            if ($urandom_range(0, 4) != 0)
                s.tick = TICK_W'($urandom_range(0, 3));
        end
        else if (roll < 96)
        begin
            s.mode = MODE_POINTER;
            if ($urandom_range(0, 3) != 0)
            begin
                s.x = last_x + CRD_W'($urandom_range(0, 2 * jit)) - CRD_W'(jit);
                s.y = last_y + CRD_W'($urandom_range(0, 2 * jit)) - CRD_W'(jit);
            end
        end
        return s;
    endfunction

    // Present one input beat after a random gap and hold it until accepted;
    // the tracker advances on the accepting edge.
    task automatic send_beat(mouse_beat_t s);
        int gap;
        gap = draw_gap(in_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        mode               <= s.mode;
        buttons            <= s.buttons;
        multi_click_wanted <= s.multi;
        tick_amount        <= s.tick;
        pointer_x          <= s.x;
        pointer_y          <= s.y;
        do
            @(posedge clk);
        while (!in_ready);
        derive_events(s);
    endtask

    task automatic offer(mouse_beat_t s);
        send_beat(s);
        queue_step();
    endtask

    // Drop valid, let every due event drain, then give a beat that made no
    // event time to leave the pipeline.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DCLICK_TICKS: win_ticks = val;
            CFG_EXTEND_TICKS: ext_ticks = val;
            CFG_MOVE_THRESH:  move_thr  = val;
            default:          ;
        endcase
    endtask

    task automatic program_regs(logic [CFG_W-1:0] d, logic [CFG_W-1:0] e,
                                logic [CFG_W-1:0] t);
        wait_idle();
        put_reg(CFG_DCLICK_TICKS, d);
        put_reg(CFG_EXTEND_TICKS, e);
        put_reg(CFG_MOVE_THRESH, t);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Event sink: stall at random, then compare each beat with the oldest
    // expected event
    // ------------------------------------------------------------------------
    initial
    begin : event_sink
        int           stall;
        click_event_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(out_idle_on);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (events_due.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("%0t: event with none expected: buttons=%h clicks=%0d last=%b",
                             $time, event_buttons, event_clicks, last_of_run);
            end
            else
            begin
                want = events_due.pop_front();
                if (event_buttons !== want.buttons || event_clicks !== want.clicks ||
                    last_of_run !== want.last)
                begin
                    faults++;
                    if (faults <= REPORT_MAX)
                    begin
                        $write("%0t: event mismatch: expected buttons=%h clicks=%0d last=%b, ",
                               $time, want.buttons, want.clicks, want.last);
                        $display("got buttons=%h clicks=%0d last=%b",
                                 event_buttons, event_clicks, last_of_run);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any beat on any channel ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("mouse_multi_click_detector_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [BTN_W-1:0] fav;
        int               p;
        int               n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan, reset registers (window 5, extend 3, threshold 2).
        // Unused mode with every field high: nothing happens.
        add_row(ROW_TYPED, beat(MODE_SPARE, 8'hFF, 1'b1, 8'hFF, 12'hFFF, 12'hFFF),
                0, NO_EVENT, NO_EVENT);
        // No waiter wants multi-clicks: press reported at once.
        add_row(ROW_TYPED, beat(MODE_BUTTON, 8'h01, 1'b0, 8'h00, 12'h000, 12'h000),
                1, '{8'h01, CLICK_ONE, 1'b1}, NO_EVENT);
        // Same state again: ignored.
        add_row(ROW_TYPED, beat(MODE_BUTTON, 8'h01, 1'b0, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TYPED, beat(MODE_BUTTON, 8'h00, 1'b0, 8'h00, 12'h000, 12'h000),
                1, '{8'h00, CLICK_ONE, 1'b1}, NO_EVENT);
        // Pointer with no window open only moves the position.
        add_row(ROW_TYPED, beat(MODE_POINTER, 8'h00, 1'b0, 8'h00, 12'hFFF, 12'hFFF),
                0, NO_EVENT, NO_EVENT);
        // Open a window, release (no click), press again (second click),
        // zero tick, partial tick, then a different state.
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h01, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h00, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h01, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_TICK, 8'h00, 1'b0, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_TICK, 8'h00, 1'b0, 8'h03, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h02, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        // Large tick ends the window: desired state with two clicks, then
        // the differing true state.
        add_row(ROW_TYPED, beat(MODE_TICK, 8'h00, 1'b0, 8'hFF, 12'h000, 12'h000),
                2, '{8'h01, 8'd2, 1'b0}, '{8'h02, CLICK_ONE, 1'b1});
        // All buttons up never opens a window.
        add_row(ROW_TYPED, beat(MODE_BUTTON, 8'h00, 1'b1, 8'h00, 12'h000, 12'h000),
                1, '{8'h00, CLICK_ONE, 1'b1}, NO_EVENT);
        // Move by exactly the threshold keeps the window, beyond it ends it.
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h80, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_POINTER, 8'h00, 1'b0, 8'h00, 12'hFFD, 12'hFFF),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TYPED, beat(MODE_POINTER, 8'h00, 1'b0, 8'h00, 12'hFFD, 12'h000),
                1, '{8'h80, CLICK_ONE, 1'b1}, NO_EVENT);
        // Tick equal to the remaining window ends it.
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'hFF, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TYPED, beat(MODE_TICK, 8'h00, 1'b0, 8'h05, 12'h000, 12'h000),
                1, '{8'hFF, CLICK_ONE, 1'b1}, NO_EVENT);
        // Zero window length: reported at once even with a waiter.
        add_regs(8'd0, 8'd0, 8'd0);
        add_row(ROW_TYPED, beat(MODE_BUTTON, 8'h04, 1'b1, 8'h00, 12'h000, 12'h000),
                1, '{8'h04, CLICK_ONE, 1'b1}, NO_EVENT);
        // Widest settings, then a jump across the whole screen.
        add_regs(8'd255, 8'd255, 8'd255);
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h00, 1'b0, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h7F, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TYPED, beat(MODE_POINTER, 8'h00, 1'b0, 8'h00, 12'h000, 12'h0FF),
                1, '{8'h7F, CLICK_ONE, 1'b1}, NO_EVENT);
        add_row(ROW_TYPED, beat(MODE_TICK, 8'h00, 1'b0, 8'h01, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        // Shortest window: one tick ends it.
        add_regs(8'd1, 8'd0, 8'd255);
        add_row(ROW_TRACKED, beat(MODE_BUTTON, 8'h55, 1'b1, 8'h00, 12'h000, 12'h000),
                0, NO_EVENT, NO_EVENT);
        add_row(ROW_TYPED, beat(MODE_TICK, 8'h00, 1'b0, 8'h01, 12'h000, 12'h000),
                1, '{8'h55, CLICK_ONE, 1'b1}, NO_EVENT);

        // Walk the plan. Typed rows still advance the tracker so that the
        // tracked rows after them start from the right state.
        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_REGS)
                program_regs(plan[r].dct, plan[r].ext, plan[r].thr);
            else
            begin
                send_beat(plan[r].stim);
                if (plan[r].kind == ROW_TRACKED)
                    queue_step();
                else
                begin
                    if (plan[r].n_ev > 0)
                        events_due.push_back(plan[r].ev0);
                    if (plan[r].n_ev > 1)
                        events_due.push_back(plan[r].ev1);
                end
            end
        end

        // Random phases, each with its own register setting and idle pattern;
        // one phase runs with no idling at all.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       program_regs(DCLICK_TICKS_RST, EXTEND_TICKS_RST, MOVE_THRESH_RST);
                1:       program_regs(8'd1, 8'd0, 8'd0);
                2:       program_regs(8'd255, 8'd255, 8'd255);
                default: program_regs(CFG_W'($urandom_range(1, 40)),
                                      CFG_W'($urandom_range(0, 255)),
                                      CFG_W'($urandom_range(0, 12)));
            endcase
            if (p == 3)
                {in_idle_on, out_idle_on} = 2'b00;
            else
                {in_idle_on, out_idle_on} = 2'($urandom_range(1, 3));
            fav = BTN_W'($urandom_range(1, 255));
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                // Switch the favorite state now and then.
                if (n % FAV_SPAN == FAV_SPAN - 1)
                    fav = BTN_W'($urandom_range(1, 255));
                offer(pick_beat(fav));
            end
        end

        // Saturation: longest window and extension, then hundreds of clicks
        // on one button so both the click count and the window length top out.
        program_regs(8'd255, 8'd255, 8'd255);
        in_idle_on  = 1'b0;
        out_idle_on = 1'($urandom_range(0, 1));
        while (delay_left != '0)
            offer(beat(MODE_TICK, 8'h00, 1'b0, 8'hFF, 12'h000, 12'h000));
        if (true_btn != '0)
            offer(beat(MODE_BUTTON, 8'h00, 1'b0, 8'h00, 12'h000, 12'h000));
        for (n = 0; n < SAT_TOGGLES; n++)
            offer(beat(MODE_BUTTON, (n % 2 == 0) ? 8'h01 : 8'h00, 1'b1, 8'h00,
                       12'h000, 12'h000));
        while (delay_left != '0)
            offer(beat(MODE_TICK, 8'h00, 1'b0, 8'hFF, 12'h000, 12'h000));

        // Drain, then watch a little longer for stray events.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("mouse_multi_click_detector_top verification clean");
        else
            $display("mouse_multi_click_detector_top verification failed");
        $finish;
    end

endmodule

// ===== mouse_multi_click_detector_top.f =====
+incdir+rtl
rtl/mcd_pkg.sv
rtl/mouse_multi_click_detector_top.sv
dv/tb.sv
